[hw/rtl/asd_pkg.sv]
package asd_pkg;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int IN_ID_W     = 8;

  // Result count field
  localparam int             COUNT_W   = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // Controller -> datapath commands
  typedef struct packed {
    logic store;      // write accepted pair into both lists
    logic walk_init;  // clear walk position, match position and total
    logic fetch;      // read first[i] and second[i], j <= i
    logic step;       // no hit yet: advance search position
    logic decide;     // search done: latch match position
    logic shift;      // move one entry forward, count it
    logic next_i;     // advance walk position
    logic emit;       // load result register, clear set state
  } asd_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic hit;    // second[j] matches first[i]
    logic j_end;  // j is the last stored position
    logic move;   // chosen match lies after i
    logic i_end;  // i is the last stored position
    logic k_end;  // current shift is the final one for this i
  } asd_sts_t;

endpackage

[hw/rtl/asd_ctrl.sv]
module asd_ctrl
  import asd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  asd_sts_t sts,
  output asd_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SRCH  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_EMIT  = 5'b10000
  } asd_state_t;

  asd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.store = 1'b1;
          if (in_tlast) begin
            cmd.walk_init = 1'b1;
            state_nxt     = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (sts.hit || sts.j_end) begin
          cmd.decide = 1'b1;
          if (sts.move) begin
            state_nxt = S_SHIFT;
          end else begin
            cmd.next_i = 1'b1;
            state_nxt  = sts.i_end ? S_EMIT : S_FETCH;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.k_end) begin
          cmd.next_i = 1'b1;
          state_nxt  = sts.i_end ? S_EMIT : S_FETCH;
        end
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;

endmodule

[hw/rtl/asd_dp.sv]
module asd_dp
  import asd_pkg::*;
#(
  parameter int MAX_LEN = 32,
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IN_ID_W-1:0] in_first_id,
  input  logic [IN_ID_W-1:0] in_second_id,
  input  asd_cmd_t           cmd,
  output asd_sts_t           sts,
  output logic [COUNT_W-1:0] swap_count,
  output logic               length_overflow
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int KW = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;

  // List stores
  logic [ID_BITS-1:0] first_mem  [MAX_LEN];
  logic [ID_BITS-1:0] second_mem [MAX_LEN];

  logic [CW-1:0]      loaded_r;
  logic               ovf_r;
  logic [AW-1:0]      i_r, j_r, k_r, match_r;
  logic [COUNT_W-1:0] total_r;
  logic [ID_BITS-1:0] first_q_r, second_q_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;

  logic [ID_BITS-1:0] id_a, id_b;
  logic               full;
  logic [AW-1:0]      wr_addr, sec_rd_addr, match_pos;

  // Low ID_BITS of each incoming identifier (the whole id, zero-extended, if ID_BITS is wider)
  assign id_a = ID_BITS'(in_first_id[KW-1:0]);
  assign id_b = ID_BITS'(in_second_id[KW-1:0]);

  assign full    = (loaded_r == CW'(MAX_LEN));
  assign wr_addr = loaded_r[AW-1:0];

  // Status toward the controller
  assign match_pos = sts.hit ? j_r : match_r;
  assign sts.hit   = (first_q_r == second_q_r);
  assign sts.j_end = ((CW'(j_r) + CW'(1)) == loaded_r);
  assign sts.move  = (match_pos > i_r);
  assign sts.i_end = ((CW'(i_r) + CW'(1)) == loaded_r);
  assign sts.k_end = ((k_r - AW'(1)) == i_r);

  // Second list read address
  always_comb begin
    if (cmd.fetch) begin
      sec_rd_addr = i_r;
    end else if (cmd.decide) begin
      sec_rd_addr = match_pos - AW'(1);
    end else if (cmd.shift) begin
      sec_rd_addr = k_r - AW'(2);
    end else begin
      sec_rd_addr = j_r + AW'(1);
    end
  end

  // Memory ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      first_mem[wr_addr]  <= id_a;
      second_mem[wr_addr] <= id_b;
    end else if (cmd.shift) begin
      second_mem[k_r] <= second_q_r;
    end
    if (cmd.fetch) begin
      first_q_r <= first_mem[i_r];
    end
    second_q_r <= second_mem[sec_rd_addr];
  end

  // Fill count, overflow flag and walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      ovf_r    <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      match_r  <= '0;
      total_r  <= '0;
    end else begin
      if (cmd.store) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          loaded_r <= loaded_r + CW'(1);
        end
      end
      if (cmd.walk_init) begin
        i_r     <= '0;
        match_r <= '0;
        total_r <= '0;
      end
      if (cmd.fetch) begin
        j_r <= i_r;
      end
      if (cmd.step) begin
        j_r <= j_r + AW'(1);
      end
      if (cmd.decide) begin
        match_r <= match_pos;
        k_r     <= match_pos;
      end
      if (cmd.shift) begin
        k_r <= k_r - AW'(1);
        if (total_r != COUNT_MAX) begin
          total_r <= total_r + COUNT_W'(1);
        end
      end
      if (cmd.next_i) begin
        i_r <= i_r + AW'(1);
      end
      if (cmd.emit) begin
        loaded_r <= '0;
        ovf_r    <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r <= total_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign swap_count      = out_count_r;
  assign length_overflow = out_ovf_r;

endmodule

[hw/rtl/adjacent_swap_distance.sv]
// Loading: one word per cycle, the final word (tlast) starts the walk.
// Walk: per position i, a fetch, then search steps along the second list until a hit
// or its end, then one shift per move, all serialised by the single read/write port
// of the second list; an emit step then loads the result once the output register is free.
// One set is handled at a time; throughput is one result per load plus walk.
// rst_n (synchronous, active low) empties the store and drops any pending result.
module adjacent_swap_distance
  import asd_pkg::*;
#(
  parameter int MAX_LEN = 32,
  parameter int ID_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] first_order_id, [15:8] second_order_id
  input  logic                   in_tlast,   // last_pair
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [8:0] swap_count, [15:9] zero
  output logic                   out_tuser   // [0] length_overflow
);

  asd_cmd_t           cmd;
  asd_sts_t           sts;
  logic [COUNT_W-1:0] swap_count;

  asd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  asd_dp #(
    .MAX_LEN (MAX_LEN),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_first_id     (in_tdata[IN_ID_W-1:0]),
    .in_second_id    (in_tdata[2*IN_ID_W-1:IN_ID_W]),
    .cmd             (cmd),
    .sts             (sts),
    .swap_count      (swap_count),
    .length_overflow (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(swap_count);

endmodule

[hw/rtl/asd_chk.sv]
module asd_chk
  import asd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Padding bits above swap_count stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:COUNT_W] == '0)
    else $error("result padding not zero");

  // Final word of a set stops the input while the walk runs
  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after final word");

  // A new result only comes out of a walk
  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a walk");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind adjacent_swap_distance asd_chk u_asd_chk (.*);

[bench/swap_distance_monitor.sv]
module swap_distance_monitor
  import asd_pkg::*;
#(
  parameter int MAX_LEN = 32,
  parameter int ID_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] first_order_id, [15:8] second_order_id
  input  logic                   in_tlast,   // last_pair
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [8:0] swap_count, [15:9] zero
  input  logic                   out_tuser,  // [0] length_overflow
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COUNT_W-1:0] swaps;
    logic               overflow;
  } distance_t;

  // Shadow copy of the set being loaded
  logic [ID_BITS-1:0] first_ids  [MAX_LEN];
  logic [ID_BITS-1:0] second_ids [MAX_LEN];
  int unsigned        stored_pairs;
  logic               pairs_dropped;

  distance_t expected_totals[$];

  assign outstanding = expected_totals.size();

  // Walk the first list, pull each match forward one place at a time.
  // A miss keeps the previous match position for this set.
  function automatic logic [COUNT_W-1:0] count_adjacent_moves(int unsigned n);
    logic [ID_BITS-1:0] order_b [MAX_LEN];
    int unsigned        total;
    int unsigned        match_at;
    order_b  = second_ids;
    total    = 0;
    match_at = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        if (first_ids[i] == order_b[j]) begin
          match_at = j;
          break;
        end
      end
      for (int k = match_at; k > i; k--) begin
        order_b[k] = order_b[k-1];
        if (total < COUNT_MAX) total++;
      end
    end
    return total[COUNT_W-1:0];
  endfunction

  always @(posedge clk) begin
    distance_t want;
    distance_t got;
    if (!rst_n) begin
      stored_pairs  = 0;
      pairs_dropped = 1'b0;
      mismatches    = 0;
      expected_totals.delete();
    end else begin
      // result side
      if (out_tvalid && out_tready) begin
        got.swaps    = out_tdata[COUNT_W-1:0];
        got.overflow = out_tuser;
        if (expected_totals.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result word swaps=%0d overflow=%0b",
                     $realtime, got.swaps, got.overflow);
          mismatches++;
        end else begin
          want = expected_totals.pop_front();
          if (got.swaps !== want.swaps || got.overflow !== want.overflow) begin
            if (mismatches < 10)
              $display("%0t: mismatch: exp swaps=%0d ovf=%0b, got swaps=%0d ovf=%0b",
                       $realtime, want.swaps, want.overflow, got.swaps, got.overflow);
            mismatches++;
          end
        end
      end
      // input side: store the pair, close the set on tlast
      if (in_tvalid && in_tready) begin
        if (stored_pairs < MAX_LEN) begin
          first_ids[stored_pairs]  = in_tdata[ID_BITS-1:0];
          second_ids[stored_pairs] = in_tdata[IN_ID_W +: ID_BITS];
          stored_pairs++;
        end else begin
          pairs_dropped = 1'b1;
        end
        if (in_tlast) begin
          want.swaps      = count_adjacent_moves(stored_pairs);
          want.overflow   = pairs_dropped;
          expected_totals = {expected_totals, want};
          stored_pairs    = 0;
          pairs_dropped   = 1'b0;
        end
      end
    end
  end

endmodule

[bench/tb.sv]
module tb;
  import asd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_PAIRS = 1950;
  localparam int STALL_LIMIT  = 20000;

  typedef logic [7:0] id_q_t[$];

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] first_order_id, [15:8] second_order_id
  logic                   in_tlast;   // last_pair
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [8:0] swap_count, [15:9] zero
  logic                   out_tuser;  // [0] length_overflow

  int mismatches;
  int outstanding;
  int sent_pairs;
  int quiet_cycles = 0;
  bit calm;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  adjacent_swap_distance DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  swap_distance_monitor monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // mostly no gap, some short, a few long; none while calm
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // n distinct random ids
  function automatic id_q_t distinct_ids(int n);
    logic [7:0] pool [256];
    logic [7:0] tmp;
    id_q_t      q;
    int         p;
    for (int i = 0; i < 256; i++) pool[i] = i[7:0];
    for (int i = 0; i < n; i++) begin
      p       = $urandom_range(i, 255);
      tmp     = pool[i];
      pool[i] = pool[p];
      pool[p] = tmp;
      q       = {q, pool[i]};
    end
    return q;
  endfunction

  function automatic id_q_t shuffled(id_q_t src);
    id_q_t      q;
    logic [7:0] tmp;
    int         p;
    q = src;
    for (int i = q.size() - 1; i > 0; i--) begin
      p    = $urandom_range(0, i);
      tmp  = q[i];
      q[i] = q[p];
      q[p] = tmp;
    end
    return q;
  endfunction

  function automatic id_q_t random_ids(int n);
    id_q_t q;
    for (int i = 0; i < n; i++) q = {q, 8'($urandom_range(0, 255))};
    return q;
  endfunction

  // one word per pair, tlast on the final one
  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_pairs++;
  endtask

  task automatic send_set(input id_q_t a, input id_q_t b);
    for (int i = 0; i < a.size(); i++)
      send_pair(a[i], b[i], i == a.size() - 1);
  endtask

  // result side back-pressure
  initial begin
    int g;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      g = idle_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // watchdog: nothing accepted for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("adjacent_swap_distance verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    id_q_t a;
    id_q_t b;
    int    kind;
    int    n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    calm       = 1'b0;
    sent_pairs = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single pair, id at the top extreme, matching
    a = '{8'hFF}; b = '{8'hFF}; send_set(a, b);
    // single pair, no match at start of set
    a = '{8'h00}; b = '{8'hFF}; send_set(a, b);
    // two swapped
    a = '{8'h00, 8'hFF}; b = '{8'hFF, 8'h00}; send_set(a, b);
    // identical lists
    a = '{8'h55, 8'hAA, 8'h0F}; b = '{8'h55, 8'hAA, 8'h0F}; send_set(a, b);
    // mismatch in the middle reuses the previous match position
    a = '{8'h01, 8'h02, 8'h03, 8'h04}; b = '{8'h04, 8'h09, 8'h01, 8'h02}; send_set(a, b);
    // reversed
    a = '{8'h10, 8'h11, 8'h12, 8'h13, 8'h14};
    b = '{8'h14, 8'h13, 8'h12, 8'h11, 8'h10};
    send_set(a, b);
    // repeated ids
    a = '{8'h07, 8'h07, 8'h07}; b = '{8'h07, 8'h08, 8'h07}; send_set(a, b);

    // random sets, mostly well-formed permutations
    while (sent_pairs < TARGET_PAIRS) begin
      calm = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        n = $urandom_range(1, 10);
        a = distinct_ids(n);
        b = shuffled(a);
      end else if (kind < 65) begin
        n = $urandom_range(11, 32);
        a = distinct_ids(n);
        b = shuffled(a);
      end else if (kind < 68) begin
        // full store, reversed for the largest count or left identical
        a = distinct_ids(32);
        b = a;
        if ($urandom_range(0, 1)) b.reverse();
      end else if (kind < 73) begin
        // more pairs than the store holds
        n = $urandom_range(33, 36);
        a = distinct_ids(n);
        b = shuffled(a);
      end else if (kind < 85) begin
        // permutation with a few entries corrupted
        n = $urandom_range(2, 12);
        a = distinct_ids(n);
        b = shuffled(a);
        repeat ($urandom_range(1, 3)) b[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
      end else begin
        n = $urandom_range(1, 12);
        a = random_ids(n);
        b = random_ids(n);
      end
      send_set(a, b);
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // drain
    while (outstanding != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("adjacent_swap_distance verification clean");
    end else begin
      $display("adjacent_swap_distance verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/asd_pkg.sv
hw/rtl/asd_ctrl.sv
hw/rtl/asd_dp.sv
hw/rtl/adjacent_swap_distance.sv
hw/rtl/asd_chk.sv
bench/swap_distance_monitor.sv
bench/tb.sv
